// ===== hw/rtl/bloom_filter_engine_macros.svh =====
// Assertion macros for the bloom filter engine.
// No dependencies; included by modules that carry assertions.
`ifndef BLOOM_FILTER_ENGINE_MACROS_SVH
`define BLOOM_FILTER_ENGINE_MACROS_SVH

// Implication checked on every edge outside reset.
`define BFE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BFE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bfe_pkg.sv =====
// Package for the bloom filter engine: sizes, command codes, hash helpers.
// No dependencies.
package bfe_pkg;
  localparam int MaxBits   = 65536;
  localparam int MaxHashes = 16;
  localparam int IdxW      = $clog2(MaxBits);
  localparam int HashW     = $clog2(MaxHashes + 1);
  localparam int NbW       = 17;
  localparam int NhW       = 5;
  localparam int WordW     = 32;
  localparam int WordsN    = MaxBits / WordW;
  localparam int WAddrW    = $clog2(WordsN);
  localparam int BitSelW   = $clog2(WordW);
  localparam int QDepth    = 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Register index, taken from paddr[2]
  localparam logic REG_NUM_BITS   = 1'b0;
  localparam logic REG_NUM_HASHES = 1'b1;

  // Payload of one input transfer.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] key;
  } in_item_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic present;
  } out_item_t;

  // Classified job handed from front to back.
  typedef struct packed {
    cmd_t              cmd;
    logic [31:0]       key;
    logic [IdxW:0]     modulus;
    logic [HashW-1:0]  count;
  } job_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction
endpackage

// ===== hw/rtl/bfe_if.sv =====
// Valid/ready channel interfaces for the bloom filter engine.
// Depends on bfe_pkg for the payload types.
interface bfe_in_if;
  logic              valid;
  logic              ready;
  bfe_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfe_out_if;
  logic               valid;
  logic               ready;
  bfe_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bloom_filter_engine.sv =====
// Bloom filter engine, MurmurHash3 x86_32, up to 65536 bits, up to 16 hashes.
// Per key hash: a hash pass, 32 modulo steps, then the memory read and write states.
// The back end takes one item at a time; a clear rewrites all 2048 memory words.
// Reset (rst_n, synchronous): registers to 65536/4, then a memory clearing pass
// over all 2048 words; the front queue takes up to two items meanwhile.
module bloom_filter_engine (
  input  logic clk,
  input  logic rst_n,
  bfe_in_if.sink    in_ch,
  bfe_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bfe_pkg::*;

  logic [NbW-1:0] nb_r;
  logic [NhW-1:0] nh_r;
  logic jv, jr;
  job_t job;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= NbW'(MaxBits); nh_r <= NhW'(4);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_NUM_BITS:   nb_r <= cfg_pwdata[NbW-1:0];
        REG_NUM_HASHES: nh_r <= cfg_pwdata[NhW-1:0];
      endcase
    end
  end
  always_comb begin
    unique case (cfg_paddr[2])
      REG_NUM_BITS:   cfg_prdata = 32'(nb_r);
      REG_NUM_HASHES: cfg_prdata = 32'(nh_r);
    endcase
  end

  bfe_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid),
    .in_ready(in_ch.ready), .in_cmd(in_ch.data.cmd), .in_key(in_ch.data.key),
    .num_bits(nb_r), .num_hashes(nh_r), .job_valid(jv), .job_ready(jr), .job(job));

  bfe_back u_back (.clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr),
    .job(job), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_present(out_ch.data.present));
endmodule

// ===== hw/rtl/bfe_front.sv =====
// Front end: accepts items, clamps the config and pushes jobs to a small queue.
// Depends on bfe_pkg and bloom_filter_engine_macros.svh.
module bfe_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  logic [31:0]            in_key,
  input  logic [bfe_pkg::NbW-1:0] num_bits,
  input  logic [bfe_pkg::NhW-1:0] num_hashes,
  output logic                   job_valid,
  input  logic                   job_ready,
  output bfe_pkg::job_t          job
);
  import bfe_pkg::*;
  `include "bloom_filter_engine_macros.svh"

  job_t q_r [QDepth];
  logic [$clog2(QDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QDepth):0]   cnt_r;
  job_t nj;
  logic push, pop;

  always_comb begin
    nj.cmd = cmd_t'(in_cmd);
    nj.key = in_key;
    if (num_bits == '0) nj.modulus = (IdxW+1)'(1);
    else if (num_bits > NbW'(MaxBits)) nj.modulus = (IdxW+1)'(MaxBits);
    else nj.modulus = num_bits[IdxW:0];
    if (num_hashes > NhW'(MaxHashes)) nj.count = HashW'(MaxHashes);
    else nj.count = num_hashes[HashW-1:0];
  end

  assign in_ready  = cnt_r != ($clog2(QDepth)+1)'(QDepth);
  assign push      = in_valid && in_ready;
  assign job_valid = cnt_r != '0;
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(pop);
    end
    if (push) q_r[wp_r] <= nj;
  end

  `BFE_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, cnt_r <= ($clog2(QDepth)+1)'(QDepth), "queue over")
  `BFE_ASSERT_IMP(a_no_pop_empty, clk, rst_n, cnt_r == '0, !pop, "pop of empty queue")
  `BFE_ASSERT_NXT(a_push_cnt, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count")
endmodule

// ===== hw/rtl/bfe_hash.sv =====
// Pipelined MurmurHash3 x86_32 of one 32-bit key with a given seed.
// Depends on bfe_pkg.
module bfe_hash (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] key,
  input  logic [31:0] seed,
  output logic        done,
  output logic [31:0] hash
);
  import bfe_pkg::*;
  logic [31:0] k1_r, k2_r, h2_r, h3_r, h4_r;
  logic [5:0]  v_r;
  logic [31:0] s1_r, t;

  assign t = rotl(s1_r ^ k2_r, 13);

  always_ff @(posedge clk) begin
    v_r  <= {v_r[4:0], start};
    k1_r <= key * 32'hcc9e2d51;
    s1_r <= seed;
    k2_r <= rotl(k1_r, 15) * 32'h1b873593;
    h2_r <= (t * 32'd5 + 32'he6546b64) ^ 32'd4;
    h3_r <= (h2_r ^ (h2_r >> 16)) * 32'h85ebca6b;
    h4_r <= (h3_r ^ (h3_r >> 13)) * 32'hc2b2ae35;
  end
  assign done = v_r[5];
  assign hash = h4_r ^ (h4_r >> 16);
endmodule

// ===== hw/rtl/bfe_back.sv =====
// Back end: runs hash, modulo and bit memory access per seed; handles clear.
// Depends on bfe_pkg, bfe_hash and bloom_filter_engine_macros.svh.
module bfe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  bfe_pkg::job_t  job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_present
);
  import bfe_pkg::*;
  `include "bloom_filter_engine_macros.svh"

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_MOD   = 7'b0001000,
    S_READ  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic [WordW-1:0] mem [WordsN];
  logic [WordW-1:0] rd_r;
  job_t j_r;
  logic [HashW-1:0] i_r;
  logic all_r;
  logic [WAddrW-1:0] clr_r;
  logic [31:0] h_r;
  logic [IdxW-1:0] idx_r;
  logic [IdxW:0] bitcnt_r;
  logic hstart, hdone;
  logic [31:0] hval;
  logic ov_r, op_r;

  bfe_hash u_hash (.clk(clk), .start(hstart), .key(j_r.key),
    .seed(32'(i_r)), .done(hdone), .hash(hval));

  assign job_ready = st_r == S_IDLE && !ov_r;
  assign hstart = st_r == S_HASH && bitcnt_r == '0;
  assign out_valid = ov_r;
  assign out_present = op_r;

  // restoring modulo: one quotient bit per cycle, 32 steps, MSB first
  logic [IdxW:0] rem_sh;
  assign rem_sh = {idx_r, h_r[5'd31 - bitcnt_r[4:0]]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; clr_r <= '0; ov_r <= 1'b0; bitcnt_r <= '0; j_r <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_INIT: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == WAddrW'(WordsN - 1)) begin
            st_r <= S_IDLE;
            // a clear command answers once the pass is over; reset does not
            if (j_r.cmd == CMD_CLEAR) begin
              ov_r <= 1'b1; op_r <= 1'b0;
            end
          end
        end
        S_IDLE: if (job_valid && !ov_r) begin
          j_r <= job; i_r <= '0; all_r <= 1'b1; clr_r <= '0; bitcnt_r <= '0;
          unique case (job.cmd)
            CMD_CLEAR: st_r <= S_INIT;
            CMD_NONE: begin ov_r <= 1'b1; op_r <= 1'b0; end
            default: if (job.count == '0) begin
              ov_r <= 1'b1; op_r <= job.cmd == CMD_QUERY;
            end else st_r <= S_HASH;
          endcase
        end
        S_HASH: begin
          bitcnt_r <= (IdxW+1)'(1);
          if (hdone) begin
            h_r <= hval; idx_r <= '0; bitcnt_r <= '0; st_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (rem_sh >= j_r.modulus) idx_r <= IdxW'(rem_sh - j_r.modulus);
          else idx_r <= IdxW'(rem_sh);
          bitcnt_r <= bitcnt_r + 1'b1;
          if (bitcnt_r == (IdxW+1)'(31)) st_r <= S_READ;
        end
        S_READ: st_r <= S_WRITE;
        S_WRITE: begin
          bitcnt_r <= '0;
          if (j_r.cmd == CMD_QUERY && !rd_r[idx_r[BitSelW-1:0]]) all_r <= 1'b0;
          if (i_r + 1'b1 == j_r.count ||
              (j_r.cmd == CMD_QUERY && !rd_r[idx_r[BitSelW-1:0]])) st_r <= S_DONE;
          else begin i_r <= i_r + 1'b1; st_r <= S_HASH; end
        end
        S_DONE: begin
          ov_r <= 1'b1;
          op_r <= j_r.cmd == CMD_QUERY && all_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_INIT) mem[clr_r] <= '0;
    else if (st_r == S_WRITE && j_r.cmd == CMD_INSERT)
      mem[idx_r[IdxW-1:BitSelW]] <= rd_r | (WordW'(1) << idx_r[BitSelW-1:0]);
    rd_r <= mem[idx_r[IdxW-1:BitSelW]];
  end

  `BFE_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(st_r), "state not one-hot")
  `BFE_ASSERT_IMP(a_insert_zero, clk, rst_n,
    $rose(ov_r) && j_r.cmd == CMD_INSERT, !op_r, "insert present")
  `BFE_ASSERT_IMP(a_no_take_busy, clk, rst_n, st_r != S_IDLE, !job_ready, "take while busy")
endmodule

// ===== bench/tb.sv =====
// Testbench for bloom_filter_engine: random and directed insert/query/clear
// traffic, checked against an in-bench bloom filter built on MurmurHash3.
// Depends on bfe_pkg, bloom_filter_engine and the bfe_in_if / bfe_out_if channel interfaces.
`timescale 1ns / 100ps

module tb;
  import bfe_pkg::*;

  typedef in_item_t req_t;

  localparam int CycleLimit = 3000000;
  localparam int HoldCycles = 3000;
  localparam int NbTab[10]   = '{65536, 8, 1000, 1, 65535, 300, 0, 131071, 2, 4096};
  localparam int NhTab[10]   = '{4, 16, 3, 1, 2, 8, 5, 1, 0, 31};
  localparam int NTab[10]    = '{300, 60, 200, 80, 200, 120, 80, 120, 80, 40};
  localparam int IdleIn[4]   = '{0, 66, 0, 26};
  localparam int IdleOut[4]  = '{0, 0, 66, 26};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bfe_in_if  in_if ();
  bfe_out_if out_if ();

  bloom_filter_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if.sink),
    .out_ch     (out_if.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // Bench-side filter state
  logic [MaxBits-1:0] bloom_bits;
  logic [16:0]        cur_num_bits;
  logic [4:0]         cur_num_hashes;

  req_t        pending_reqs[$];
  logic        exp_present[$];
  logic [31:0] inserted_keys[$];
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_off = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  function automatic logic [31:0] rot_left(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur32(logic [31:0] key, logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] k;
    k = key * 32'hcc9e2d51;
    k = rot_left(k, 15);
    k = k * 32'h1b873593;
    h = seed ^ k;
    h = rot_left(h, 13);
    h = h * 32'd5 + 32'he6546b64;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Applies one accepted request to the bench filter, returns expected present
  function automatic logic predict_bloom(req_t r);
    logic [31:0] m;
    logic [31:0] n;
    logic [15:0] idx;
    logic        all_set;
    m = (cur_num_bits == '0) ? 32'd1 :
        (cur_num_bits > 17'(MaxBits)) ? 32'(MaxBits) : 32'(cur_num_bits);
    n = (cur_num_hashes > 5'(MaxHashes)) ? 32'(MaxHashes) : 32'(cur_num_hashes);
    all_set = 1'b1;
    case (r.cmd)
      CMD_INSERT: begin
        for (int i = 0; i < int'(n); i++) begin
          idx = 16'(murmur32(r.key, 32'(i)) % m);
          bloom_bits[idx] = 1'b1;
        end
        return 1'b0;
      end
      CMD_QUERY: begin
        for (int i = 0; i < int'(n); i++) begin
          idx = 16'(murmur32(r.key, 32'(i)) % m);
          if (!bloom_bits[idx]) all_set = 1'b0;
        end
        return all_set;
      end
      CMD_CLEAR: begin
        bloom_bits = '0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Input driver: one nonblocking update per signal per edge
  always @(posedge clk) begin
    logic nxt_valid;
    req_t nxt_data;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      nxt_valid = in_if.valid;
      nxt_data  = in_if.data;
      if (in_if.valid && in_if.ready) begin
        exp_present.push_back(predict_bloom(in_if.data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_reqs.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt_data  = pending_reqs.pop_front();
        nxt_valid = 1'b1;
      end
      in_if.valid <= nxt_valid;
      in_if.data  <= nxt_data;
    end
  end

  // Long receiver hold-off, counted in its own process
  initial begin
    wait (hold_go);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Result side: random stall, long hold-off on request, transfer check
  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (exp_present.size() == 0) begin
          report_mismatch("unexpected result", out_if.data.present, 1'b0);
        end else begin
          want = exp_present.pop_front();
          if (out_if.data.present !== want)
            report_mismatch("present", out_if.data.present, want);
        end
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == {REG_NUM_BITS, 2'b00}) cur_num_bits = value[16:0];
    else if (addr == {REG_NUM_HASHES, 2'b00}) cur_num_hashes = value[4:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_filter(logic [31:0] nbits, logic [31:0] nhash);
    cfg_write({REG_NUM_BITS, 2'b00}, nbits);
    cfg_write({REG_NUM_HASHES, 2'b00}, nhash);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_if.valid || exp_present.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_req(cmd_t c, logic [31:0] k);
    req_t r;
    r.cmd = c;
    r.key = k;
    pending_reqs.push_back(r);
  endtask

  // Mostly inserts and queries of known keys so that queries hit set bits
  task automatic add_random_req();
    int sel;
    logic [31:0] k;
    sel = $urandom_range(99);
    k = $urandom;
    if (sel < 2) begin
      add_req(CMD_CLEAR, k);
    end else if (sel < 5) begin
      add_req(CMD_NONE, k);
    end else if (sel < 45) begin
      add_req(CMD_INSERT, k);
      inserted_keys.push_back(k);
      if (inserted_keys.size() > 200) void'(inserted_keys.pop_front());
    end else begin
      if (inserted_keys.size() > 0 && $urandom_range(9) < 7)
        k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      add_req(CMD_QUERY, k);
    end
  endtask

  initial begin
    bloom_bits     = '0;
    cur_num_bits   = 17'd65536;
    cur_num_hashes = 5'd4;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, key extremes, unknown command, clear
    add_req(CMD_INSERT, 32'h0);
    add_req(CMD_QUERY, 32'h0);
    add_req(CMD_QUERY, 32'hFFFFFFFF);
    add_req(CMD_INSERT, 32'hFFFFFFFF);
    add_req(CMD_QUERY, 32'hFFFFFFFF);
    add_req(CMD_NONE, 32'hA5A5A5A5);
    add_req(CMD_QUERY, 32'h5A5A5A5A);
    add_req(CMD_CLEAR, 32'h0);
    add_req(CMD_QUERY, 32'h0);
    add_req(CMD_INSERT, 32'h12345678);
    wait_drained();
    // zero modulus and zero hashes
    set_filter(0, 0);
    add_req(CMD_QUERY, 32'hDEADBEEF);
    add_req(CMD_INSERT, 32'hDEADBEEF);
    wait_drained();
    set_filter(1, 1);
    add_req(CMD_INSERT, 32'h1);
    add_req(CMD_QUERY, 32'h77777777);
    wait_drained();
    // oversized modulus, too many hashes
    set_filter(131071, 31);
    add_req(CMD_INSERT, 32'h80000000);
    add_req(CMD_QUERY, 32'h80000000);
    add_req(CMD_QUERY, 32'h00000001);
    wait_drained();
    // modulus change keeps the array; clear reaches bits beyond the modulus
    set_filter(100, 3);
    add_req(CMD_QUERY, 32'h80000000);
    add_req(CMD_CLEAR, 32'hFFFFFFFF);
    wait_drained();
    set_filter(65536, 16);
    add_req(CMD_QUERY, 32'h80000000);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      set_filter(NbTab[p], NhTab[p]);
      in_idle_pct   = IdleIn[p % 4];
      out_stall_pct = IdleOut[p % 4];
      if (p == 0) hold_go = 1'b1;
      for (int i = 0; i < NTab[p]; i++) add_random_req();
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bfe_pkg.sv
hw/rtl/bfe_if.sv
hw/rtl/bfe_front.sv
hw/rtl/bfe_hash.sv
hw/rtl/bfe_back.sv
hw/rtl/bloom_filter_engine.sv
bench/tb.sv
